FILE: hw/rtl/b7p_pkg.sv
// Shared types, widths and the code byte function for the 8b to 7b parity packer.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package b7p_pkg;

    localparam int DATA_W      = 8;
    localparam int GROUP_W     = 7;
    localparam int CODE_W      = 8;
    localparam int PEND_W      = 6;
    localparam int CNT_W       = 3;
    localparam int ACC_W       = PEND_W + DATA_W;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CNT_W-1:0] MAX_PEND = CNT_W'(PEND_W);

    // One classified byte: one or two code bytes ready to be sent.
    typedef struct packed {
        logic [CODE_W-1:0] code0;
        logic [CODE_W-1:0] code1;
        logic              two;
        logic              fin;
    } b7p_entry_t;

    // Seven data bits in 7..1 and even parity in bit 0.
    function automatic logic [CODE_W-1:0] make_code(input logic [GROUP_W-1:0] group);
        make_code = {group, ^group};
    endfunction

endpackage

FILE: hw/rtl/b7p_front.sv
// Front end of the packer: takes bytes, regroups the bit stream into 7-bit groups
// and forms one queue entry per byte. Depends on b7p_pkg.
`timescale 1ns / 1ps

module b7p_front
    import b7p_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [DATA_W-1:0] data_byte,
    input  logic              final_byte,
    output b7p_entry_t        entry,
    output logic [CNT_W-1:0]  pend_cnt
);

    logic [PEND_W-1:0] pend_bits_reg;
    logic [PEND_W-1:0] pend_bits_next;
    logic [CNT_W-1:0]  pend_cnt_reg;
    logic [CNT_W-1:0]  pend_cnt_next;
    logic [PEND_W-1:0] pend_mask;
    logic [ACC_W-1:0]  acc;
    logic [ACC_W-1:0]  aligned;
    logic              six_waiting;

    always_comb
    begin
        // Only the low pend_cnt bits of the stored byte are still waiting.
        pend_mask   = ~({PEND_W{1'b1}} << pend_cnt_reg);
        acc         = {pend_bits_reg & pend_mask, data_byte};
        // Left-align the valid bits so the first group sits in the top seven bits
        // and a padded leftover group falls out with zeros below it.
        aligned     = acc << (MAX_PEND - pend_cnt_reg);
        six_waiting = (pend_cnt_reg == MAX_PEND);

        entry.code0 = make_code(aligned[ACC_W-1:GROUP_W]);
        entry.code1 = make_code(aligned[GROUP_W-1:0]);
        entry.two   = six_waiting | final_byte;
        entry.fin   = final_byte;

        if (final_byte || six_waiting)
        begin
            pend_cnt_next = '0;
        end
        else
        begin
            pend_cnt_next = pend_cnt_reg + CNT_W'(1);
        end
        pend_bits_next = final_byte ? '0 : data_byte[PEND_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
        end
        else if (take)
        begin
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
        end
    end

    assign pend_cnt = pend_cnt_reg;

endmodule

FILE: hw/rtl/b7p_queue.sv
// Short queue of classified entries between the front end and the back end.
// Depends on b7p_pkg.
`timescale 1ns / 1ps

module b7p_queue
    import b7p_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  b7p_entry_t wr_data,
    output logic       full,
    input  logic       rd_en,
    output b7p_entry_t rd_data,
    output logic       empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_QW = $clog2(DEPTH + 1);

    b7p_entry_t         mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_QW-1:0]  count_reg;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] ptr);
        if (ptr == PTR_W'(DEPTH - 1))
        begin
            bump = '0;
        end
        else
        begin
            bump = ptr + PTR_W'(1);
        end
    endfunction

    assign full    = (count_reg == CNT_QW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + CNT_QW'(1);
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - CNT_QW'(1);
            end
        end
    end

endmodule

FILE: hw/rtl/b7p_back.sv
// Back end of the packer: sends the one or two code bytes of each queue entry
// through an output register. Depends on b7p_pkg.
`timescale 1ns / 1ps

module b7p_back
    import b7p_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  b7p_entry_t        head,
    input  logic              head_empty,
    output logic              head_take,
    output logic              mid_entry,
    output logic [CODE_W-1:0] code_byte,
    output logic              last_code,
    output logic              empty,
    input  logic              pop
);

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [CODE_W-1:0] out_code_reg;
    logic [CODE_W-1:0] out_code_next;
    logic              out_last_reg;
    logic              out_last_next;
    logic              phase_reg;
    logic              phase_next;
    logic              load;
    logic              entry_done;

    always_comb
    begin
        // The output register takes a new code byte when it is empty or being drained.
        load       = !out_valid_reg || pop;
        entry_done = phase_reg || !head.two;
        head_take  = load && !head_empty && entry_done;

        out_valid_next = out_valid_reg;
        out_code_next  = out_code_reg;
        out_last_next  = out_last_reg;
        phase_next     = phase_reg;

        if (load)
        begin
            out_valid_next = !head_empty;
            if (!head_empty)
            begin
                out_code_next = phase_reg ? head.code1 : head.code0;
                out_last_next = head.fin && phase_reg;
                phase_next    = !entry_done;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_code_reg <= out_code_next;
        out_last_reg <= out_last_next;
    end

    assign code_byte = out_code_reg;
    assign last_code = out_last_reg;
    assign empty     = !out_valid_reg;
    assign mid_entry = phase_reg;

endmodule

FILE: hw/rtl/byte_to_seven_bit_parity_packer.sv
// Top level of the 8b to 7b regrouping packer with even parity.
// Depends on b7p_pkg, b7p_front, b7p_queue and b7p_back.
//
// Bytes enter MSB first on a queue-style port (push/full) and code bytes leave on
// another (empty/pop), each holding seven stream bits in 7..1 and even parity in
// bit 0; the last code byte of a message carries last_code. A byte that is taken
// goes through the queue and then the output register before it can be popped.
// The block takes one byte per cycle while pop is held and each byte yields one
// code byte; a byte that completes two groups (six bits carried over) or a final
// byte yields two, and the single-register output port, one code byte per cycle,
// then sets the rate at which bytes are taken. A queue of QUEUE_DEPTH classified
// bytes separates intake from output so either side may stall on its own.
`timescale 1ns / 1ps

module byte_to_seven_bit_parity_packer
    import b7p_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [DATA_W-1:0] data_byte,
    input  logic              final_byte,
    output logic              empty,
    input  logic              pop,
    output logic [CODE_W-1:0] code_byte,
    output logic              last_code
);

    b7p_entry_t       front_entry;
    b7p_entry_t       head_entry;
    logic [CNT_W-1:0] pend_cnt;
    logic             take;
    logic             q_full;
    logic             q_empty;
    logic             head_take;
    logic             mid_entry;

    assign take = push && !q_full;
    assign full = q_full;

    b7p_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .entry      (front_entry),
        .pend_cnt   (pend_cnt)
    );

    b7p_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (take),
        .wr_data (front_entry),
        .full    (q_full),
        .rd_en   (head_take),
        .rd_data (head_entry),
        .empty   (q_empty)
    );

    b7p_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head_entry),
        .head_empty (q_empty),
        .head_take  (head_take),
        .mid_entry  (mid_entry),
        .code_byte  (code_byte),
        .last_code  (last_code),
        .empty      (empty),
        .pop        (pop)
    );

    // At most six stream bits ever wait for the next byte.
    a_pend_limit: assert property (@(posedge clk) disable iff (!rst_n)
        pend_cnt <= MAX_PEND)
        else $error("pending bit count above six");

    // A final byte leaves nothing waiting for the next message.
    a_flush: assert property (@(posedge clk) disable iff (!rst_n)
        take && final_byte |=> pend_cnt == '0)
        else $error("bits left waiting after final byte");

    // While the second code byte of an entry is due, that entry is still queued.
    a_mid_held: assert property (@(posedge clk) disable iff (!rst_n)
        mid_entry |-> !q_empty)
        else $error("second code byte due with no entry queued");

endmodule

FILE: test/code_byte_monitor.sv
// Monitor for the 8b to 7b parity packer: it watches both queue ports,
// predicts the code bytes of every accepted input byte and compares them in order.
// Depends on b7p_pkg for the widths.
`timescale 1ns / 1ps

module code_byte_monitor
    import b7p_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic              full,
    input  logic [DATA_W-1:0] data_byte,
    input  logic              final_byte,
    input  logic              empty,
    input  logic              pop,
    input  logic [CODE_W-1:0] code_byte,
    input  logic              last_code,
    output int                mismatches,
    output int                waiting
);

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              last;
    } code_item_t;

    code_item_t        expected_codes[$];
    code_item_t        oldest;
    logic [PEND_W-1:0] carry_bits;
    logic [CNT_W-1:0]  carry_count;

    // Regroups one byte into the stream and queues the code bytes it completes.
    task pack_byte(input logic [DATA_W-1:0] data, input logic fin);
        logic [31:0]        acc;
        logic [GROUP_W-1:0] grp;
        code_item_t         outs[3];
        int                 total;
        int                 n;
        int                 cnt;
        cnt = (carry_count > 3'd6) ? 6 : int'(carry_count);
        acc = ((32'(carry_bits) & ((32'd1 << cnt) - 32'd1)) << 8) | 32'(data);
        total = cnt + 8;
        n = 0;
        while (total >= GROUP_W && n < 2)
        begin
            grp = GROUP_W'(acc >> (total - GROUP_W));
            outs[n] = '{code: {grp, ^grp}, last: 1'b0};
            total -= GROUP_W;
            acc &= (32'd1 << total) - 32'd1;
            n++;
        end
        if (fin)
        begin
            // Leftover bits are padded with zeros at the end of the group.
            if (total > 0)
            begin
                grp = GROUP_W'(acc << (GROUP_W - total));
                outs[n] = '{code: {grp, ^grp}, last: 1'b0};
                n++;
            end
            outs[n - 1].last = 1'b1;
            carry_bits = '0;
            carry_count = '0;
        end
        else
        begin
            carry_bits = acc[PEND_W-1:0];
            carry_count = CNT_W'(total);
        end
        for (int i = 0; i < n; i++)
            expected_codes.push_back(outs[i]);
    endtask

    task note_mismatch(input string what);
        if (mismatches < 10)
            $display("%0t: %s", $realtime, what);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_bits = '0;
            carry_count = '0;
            expected_codes.delete();
            mismatches = 0;
            waiting <= 0;
        end
        else
        begin
            // Results are checked before the new byte is predicted, since a byte
            // can never reach the output at the edge it is taken in.
            if (pop && !empty)
            begin
                if (expected_codes.size() == 0)
                    note_mismatch($sformatf("unexpected code byte %h last %0d",
                                            code_byte, last_code));
                else
                begin
                    oldest = expected_codes.pop_front();
                    if (code_byte !== oldest.code || last_code !== oldest.last)
                        note_mismatch($sformatf(
                            "code byte expected %h last %0d, got %h last %0d",
                            oldest.code, oldest.last, code_byte, last_code));
                end
            end
            if (push && !full)
                pack_byte(data_byte, final_byte);
            waiting <= expected_codes.size();
        end
    end

endmodule

FILE: test/tb_byte_to_seven_bit_parity_packer.sv
// Testbench top for the 8b to 7b parity packer: clock, reset, byte messages on
// the input queue port, random stalls on the output, and the verdict.
// Depends on b7p_pkg, byte_to_seven_bit_parity_packer and code_byte_monitor.
`timescale 1ns / 1ps

module tb_byte_to_seven_bit_parity_packer;
    import b7p_pkg::*;

    localparam int RANDOM_BYTES = 1200;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DIR_COUNT    = 25;

    // Directed messages: one zero byte, one all-ones byte, two single-bit bytes,
    // seven bytes (two code bytes on the final one and no padding), six bytes
    // (padding on the final one) and eight all-ones bytes.
    localparam logic [DATA_W-1:0] DIRECTED [0:DIR_COUNT-1] = '{
        8'h00, 8'hFF, 8'h80, 8'h01,
        8'hAA, 8'h55, 8'hFF, 8'h00, 8'h81, 8'h7E, 8'hC3,
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20,
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF
    };
    localparam logic [DIR_COUNT-1:0] DIRECTED_FINAL =
        (25'd1 << 0) | (25'd1 << 1) | (25'd1 << 3) | (25'd1 << 10) |
        (25'd1 << 16) | (25'd1 << 24);

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              push = 1'b0;
    logic              full;
    logic [DATA_W-1:0] data_byte = '0;
    logic              final_byte = 1'b0;
    logic              empty;
    logic              pop = 1'b0;
    logic [CODE_W-1:0] code_byte;
    logic              last_code;
    logic              steady = 1'b0;
    int                mismatches;
    int                waiting;
    int                cycles = 0;

    always #1 clk = ~clk;

    byte_to_seven_bit_parity_packer DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .empty      (empty),
        .pop        (pop),
        .code_byte  (code_byte),
        .last_code  (last_code)
    );

    code_byte_monitor monitor (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .empty      (empty),
        .pop        (pop),
        .code_byte  (code_byte),
        .last_code  (last_code),
        .mismatches (mismatches),
        .waiting    (waiting)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Called at a clock edge; returns at the edge where the transaction is taken.
    task send_byte(input logic [DATA_W-1:0] value, input logic fin);
        int gap;
        gap = steady ? 0 : idle_len();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        data_byte <= value;
        final_byte <= fin;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Output side: pop runs broken by random stalls, none during steady stretches.
    initial
    begin
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (steady)
                pop <= 1'b1;
            else if (stall > 0)
            begin
                pop <= 1'b0;
                stall--;
            end
            else
            begin
                pop <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall = idle_len();
            end
        end
    end

    initial
    begin
        int sent;
        int len;
        int r;
        int fill;
        logic [DATA_W-1:0] value;
        sent = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_COUNT; i++)
            send_byte(DIRECTED[i], DIRECTED_FINAL[i]);

        while (sent < RANDOM_BYTES)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                len = $urandom_range(1, 7);
            else if (r < 70)
                len = $urandom_range(8, 16);
            else if (r < 90)
                len = 7 * $urandom_range(1, 3);
            else
                len = $urandom_range(17, 40);
            // A few messages are a constant fill to hit all-zero and all-one groups.
            fill = $urandom_range(0, 9);
            steady <= ($urandom_range(0, 6) == 0);
            for (int k = 0; k < len; k++)
            begin
                if (fill == 0)
                    value = '0;
                else if (fill == 1)
                    value = '1;
                else
                    value = DATA_W'($urandom);
                send_byte(value, k == len - 1);
                sent++;
            end
        end
        push <= 1'b0;
        steady <= 1'b0;

        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
